>>> hdl/fwpg_pkg.sv
package fwpg_pkg;

    typedef struct packed {
        logic [31:0] price;
        logic [31:0] tick_time;
        logic        day_end;
    } tick_t;

    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] peak_time;
        logic [23:0] gain;
        logic        last_of_run;
    } rec_t;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [23:0] gain;
    } div_stat_t;

    localparam logic [1:0] CFG_GAIN_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WARMUP_TICKS   = 2'd1;
    localparam logic [1:0] CFG_WINDOW_LEN     = 2'd2;

    localparam logic [23:0] GAIN_THRESHOLD_RST = 24'd983;
    localparam logic [7:0]  WARMUP_TICKS_RST   = 8'd30;
    localparam logic [6:0]  WINDOW_LEN_RST     = 7'd50;

    localparam logic [23:0] GAIN_MAX  = 24'hFFFFFF;
    localparam logic [7:0]  TICKS_MAX = 8'd255;
    localparam int          QDEPTH    = 2;

endpackage

>>> hdl/forward_window_peak_gain.sv
// each item leaves the input queue and passes the absorb, check, open and flush states;
// a closing start is checked and, if its price rose, waits on the 24-step serial Q8.16
// divider (skipped if the gain saturates), then passes the emit state if it emits a record
// warmup items are dropped before the queue; the back end takes a new item only when idle,
// so the divider and the serial day-end close sweep (up to MAX_WINDOW starts) set the rate
// reset: aresetn synchronous active low, clears control state and loads register defaults
module forward_window_peak_gain
    import fwpg_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  tick_t       s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rec_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int PW = (PRICE_BITS < 32) ? PRICE_BITS : 32;

    logic [23:0] gain_threshold_reg;
    logic [7:0]  warmup_ticks_reg;
    logic [6:0]  window_len_reg;

    logic          q_push;
    tick_t         q_in_data;
    logic          q_in_ready;
    logic          q_out_valid;
    tick_t         q_out_data;
    logic          q_out_ready;
    logic          div_start;
    logic [PW-1:0] div_base_price;
    logic [PW-1:0] div_peak_price;
    div_stat_t     div_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_threshold_reg <= GAIN_THRESHOLD_RST;
            warmup_ticks_reg   <= WARMUP_TICKS_RST;
            window_len_reg     <= WINDOW_LEN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GAIN_THRESHOLD: gain_threshold_reg <= cfg_data;
                CFG_WARMUP_TICKS:   warmup_ticks_reg   <= cfg_data[7:0];
                CFG_WINDOW_LEN:     window_len_reg     <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    fwpg_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .warmup_ticks (warmup_ticks_reg),
        .q_push       (q_push),
        .q_data       (q_in_data),
        .q_ready      (q_in_ready)
    );

    fwpg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_data   (q_in_data),
        .in_ready  (q_in_ready),
        .out_valid (q_out_valid),
        .out_data  (q_out_data),
        .out_ready (q_out_ready)
    );

    fwpg_div #(
        .PW (PW)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .base_price (div_base_price),
        .peak_price (div_peak_price),
        .stat       (div_stat)
    );

    fwpg_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .PW         (PW)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_out_valid),
        .q_data         (q_out_data),
        .q_ready        (q_out_ready),
        .window_len     (window_len_reg),
        .gain_threshold (gain_threshold_reg),
        .div_start      (div_start),
        .div_base_price (div_base_price),
        .div_peak_price (div_peak_price),
        .div_stat       (div_stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

`ifndef ASSERT_OFF
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_in_ready)
        else $error("item pushed into full queue");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |=> !div_stat.done)
        else $error("divider done held longer than one cycle");
`endif

endmodule

>>> hdl/fwpg_front.sv
module fwpg_front
    import fwpg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  tick_t      s_data,
    input  logic [7:0] warmup_ticks,
    output logic       q_push,
    output tick_t      q_data,
    input  logic       q_ready
);

    logic [7:0] ticks_today_reg;
    logic [7:0] ticks_today_next;
    logic       accept;
    logic       active;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;
    // warmup items are counted and dropped here
    assign active  = ticks_today_reg >= warmup_ticks;
    assign q_push  = accept && active;
    assign q_data  = s_data;

    always_comb begin
        ticks_today_next = ticks_today_reg;
        if (accept) begin
            if (s_data.day_end) begin
                ticks_today_next = '0;
            end else if (ticks_today_reg != TICKS_MAX) begin
                ticks_today_next = ticks_today_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_today_reg <= '0;
        end else begin
            ticks_today_reg <= ticks_today_next;
        end
    end

endmodule

>>> hdl/fwpg_fifo.sv
module fwpg_fifo
    import fwpg_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  tick_t in_data,
    output logic  in_ready,
    output logic  out_valid,
    output tick_t out_data,
    input  logic  out_ready
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int NW = $clog2(QDEPTH + 1);

    tick_t         mem_reg [QDEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          wr_en;
    logic          rd_en;

    assign in_ready  = count_reg != NW'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign wr_en     = push && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + NW'(1);
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

>>> hdl/fwpg_div.sv
module fwpg_div
    import fwpg_pkg::*;
#(
    parameter int PW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [PW-1:0] base_price,
    input  logic [PW-1:0] peak_price,
    output div_stat_t     stat
);

    logic [PW-1:0] den_reg;
    logic [PW-1:0] rem_reg;
    logic [23:0]   low_reg;
    logic [23:0]   quo_reg;
    logic [4:0]    step_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [PW-1:0] diff;
    logic          sat;
    logic [PW:0]   trial;
    logic          fits;

    assign diff  = peak_price - base_price;
    // gain of 256.0 or more
    assign sat   = {8'h00, diff} >= {base_price, 8'h00};
    assign trial = {rem_reg, low_reg[23]};
    assign fits  = trial >= {1'b0, den_reg};

    assign stat.done = done_reg;
    assign stat.busy = busy_reg;
    assign stat.gain = quo_reg;

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            den_reg  <= base_price;
            rem_reg  <= PW'(diff >> 8);
            low_reg  <= {diff[7:0], 16'h0000};
            quo_reg  <= (base_price == '0 || sat) ? GAIN_MAX : '0;
            step_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? PW'(trial - {1'b0, den_reg}) : trial[PW-1:0];
            low_reg  <= {low_reg[22:0], 1'b0};
            quo_reg  <= {quo_reg[22:0], fits};
            step_reg <= step_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                if (base_price == '0 || sat) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg && step_reg == 5'd23) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

>>> hdl/fwpg_back.sv
module fwpg_back
    import fwpg_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int PW         = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  tick_t         q_data,
    output logic          q_ready,
    input  logic [6:0]    window_len,
    input  logic [23:0]   gain_threshold,
    output logic          div_start,
    output logic [PW-1:0] div_base_price,
    output logic [PW-1:0] div_peak_price,
    input  div_stat_t     div_stat,
    output logic          m_valid,
    input  logic          m_ready,
    output rec_t          m_data
);

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam logic [6:0] WIN_CAP = (MAX_WINDOW > 127) ? 7'd127 : 7'(MAX_WINDOW);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ABSORB = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_EMIT   = 7'b0010000,
        ST_OPEN   = 7'b0100000,
        ST_FLUSH  = 7'b1000000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    tick_t         cur_reg;
    logic [PW-1:0] cur_price;

    logic [PW-1:0] base_price_reg [MAX_WINDOW];
    logic [PW-1:0] peak_price_reg  [MAX_WINDOW];
    logic [31:0]   start_time_reg  [MAX_WINDOW];
    logic [31:0]   peak_time_reg   [MAX_WINDOW];
    logic [6:0]    seen_reg        [MAX_WINDOW];
    logic          valid_reg       [MAX_WINDOW];
    logic [CW-1:0] count_reg;

    rec_t pend_reg;
    logic pend_valid_reg;
    rec_t m_data_reg;
    logic m_valid_reg;

    logic [6:0] win;
    logic       head_close;
    logic       head_rise;
    logic       out_free;
    logic       gain_hit;
    rec_t       new_rec;
    rec_t       out_data;
    logic       do_absorb;
    logic       do_shift;
    logic       do_open;
    logic       do_clear;
    logic       load_out;
    logic       pend_load;
    logic       pend_drop;

    assign cur_price  = cur_reg.price[PW-1:0];
    assign win        = (window_len > WIN_CAP) ? WIN_CAP : window_len;
    assign head_close = valid_reg[0] && (seen_reg[0] >= win || cur_reg.day_end);
    assign head_rise  = peak_price_reg[0] > base_price_reg[0];
    assign out_free   = !m_valid_reg || m_ready;
    assign gain_hit   = div_stat.gain > gain_threshold;
    assign q_ready    = state_reg == ST_IDLE;

    assign div_base_price = base_price_reg[0];
    assign div_peak_price = peak_price_reg[0];

    assign new_rec.start_time  = start_time_reg[0];
    assign new_rec.peak_time   = peak_time_reg[0];
    assign new_rec.gain        = div_stat.gain;
    assign new_rec.last_of_run = 1'b0;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next = state_reg;
        do_absorb  = 1'b0;
        do_shift   = 1'b0;
        do_open    = 1'b0;
        do_clear   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        pend_load  = 1'b0;
        pend_drop  = 1'b0;
        out_data   = pend_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                do_absorb  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (head_close) begin
                    if (head_rise) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        do_shift = 1'b1;
                    end
                end else begin
                    state_next = ST_OPEN;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (gain_hit) begin
                        state_next = ST_EMIT;
                    end else begin
                        do_shift   = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_EMIT: begin
                // held record goes out here when a later one shows it is not last
                if (!pend_valid_reg) begin
                    pend_load  = 1'b1;
                    do_shift   = 1'b1;
                    state_next = ST_CHECK;
                end else if (out_free) begin
                    load_out   = 1'b1;
                    pend_load  = 1'b1;
                    do_shift   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_OPEN: begin
                if (cur_reg.day_end) begin
                    do_clear = 1'b1;
                end else if (win != '0 && count_reg != CW'(MAX_WINDOW)) begin
                    do_open = 1'b1;
                end
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    load_out             = 1'b1;
                    out_data.last_of_run = 1'b1;
                    pend_drop            = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            count_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (pend_load) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_drop) begin
                pend_valid_reg <= 1'b0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (do_clear) begin
                count_reg <= '0;
            end else if (do_shift) begin
                count_reg <= count_reg - CW'(1);
            end else if (do_open) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            cur_reg <= q_data;
        end
        if (pend_load) begin
            pend_reg <= new_rec;
        end
        if (load_out) begin
            m_data_reg <= out_data;
        end
    end

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_lane
        logic          nxt_valid;
        logic [6:0]    nxt_seen;
        logic [PW-1:0] nxt_base_price;
        logic [PW-1:0] nxt_peak_price;
        logic [31:0]   nxt_start_time;
        logic [31:0]   nxt_peak_time;
        logic          open_here;
        logic          live;

        if (i < MAX_WINDOW - 1) begin : g_mid
            assign nxt_valid      = valid_reg[i+1];
            assign nxt_seen       = seen_reg[i+1];
            assign nxt_base_price = base_price_reg[i+1];
            assign nxt_peak_price = peak_price_reg[i+1];
            assign nxt_start_time = start_time_reg[i+1];
            assign nxt_peak_time  = peak_time_reg[i+1];
        end else begin : g_end
            assign nxt_valid      = 1'b0;
            assign nxt_seen       = '0;
            assign nxt_base_price = base_price_reg[i];
            assign nxt_peak_price = peak_price_reg[i];
            assign nxt_start_time = start_time_reg[i];
            assign nxt_peak_time  = peak_time_reg[i];
        end

        assign open_here = do_open && count_reg[IW-1:0] == IW'(i);
        assign live      = valid_reg[i] && seen_reg[i] < win;

        always_ff @(posedge aclk) begin
            if (do_absorb) begin
                if (live && cur_price > peak_price_reg[i]) begin
                    peak_price_reg[i] <= cur_price;
                    peak_time_reg[i]  <= cur_reg.tick_time;
                end
            end else if (do_shift) begin
                base_price_reg[i] <= nxt_base_price;
                peak_price_reg[i] <= nxt_peak_price;
                start_time_reg[i] <= nxt_start_time;
                peak_time_reg[i]  <= nxt_peak_time;
            end else if (open_here) begin
                base_price_reg[i] <= cur_price;
                peak_price_reg[i] <= cur_price;
                start_time_reg[i] <= cur_reg.tick_time;
                peak_time_reg[i]  <= cur_reg.tick_time;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
                seen_reg[i]  <= '0;
            end else if (do_clear) begin
                valid_reg[i] <= 1'b0;
                seen_reg[i]  <= '0;
            end else if (do_absorb) begin
                if (live) begin
                    seen_reg[i] <= seen_reg[i] + 7'd1;
                end
            end else if (do_shift) begin
                valid_reg[i] <= nxt_valid;
                seen_reg[i]  <= nxt_seen;
            end else if (open_here) begin
                valid_reg[i] <= 1'b1;
                seen_reg[i]  <= '0;
            end
        end
    end

endmodule
